### src/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants for the triangle plane clipper
// Fixed-point widths, register indexes, pipeline payload structs and the
// shared one-step divide helper.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;          // v - p
  localparam int NORM_FRAC  = 24;                   // unit normal in Q.24
  localparam int QN_W       = NORM_FRAC + 1;        // |nhat| <= 2^24
  localparam int NHAT_W     = QN_W + 1;
  localparam int PROD_W     = NHAT_W + DIFF_W;
  localparam int DIST_W     = PROD_W + 1;           // sum of three products
  localparam int DIV_W      = DIST_W + 1;           // remainder after shift
  localparam int T_FRAC     = 30;                   // t in Q0.30
  localparam int DIV_STAGES = T_FRAC / 2;           // two quotient bits a stage
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd5;

  // number of inside vertices, as it decides the output shape
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_ALL  = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [2:0]              vec_t;     // [0]=x [1]=y [2]=z
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef diff_t [2:0]               dvec_t;
  typedef logic signed [NHAT_W-1:0]  nhat_t;
  typedef logic signed [DIST_W-1:0]  dist_t;

  typedef struct packed {
    logic [1:0]         count;
    logic [COORD_W-1:0] color;
    vec_t [2:0]         w;     // kept vertices: I0, I1 (or v0..v2 when all in)
    dvec_t              da;    // b - a of first crossing edge
    dvec_t              db;    // b - a of second crossing edge
  } clip_t;

  typedef struct packed {
    logic [DIV_W-1:0]  r;
    logic [T_FRAC-1:0] q;
  } qr_t;

  typedef struct packed {
    qr_t              a;
    qr_t              b;
    logic [DIV_W-1:0] dena;
    logic [DIV_W-1:0] denb;
  } div_t;

  function automatic qr_t div_step(qr_t s, logic [DIV_W-1:0] den);
    logic [DIV_W-1:0] sh;
    qr_t              o;
    sh = {s.r[DIV_W-2:0], 1'b0};
    if (sh >= den) begin
      o.r = sh - den;
      o.q = {s.q[T_FRAC-2:0], 1'b1};
    end else begin
      o.r = sh;
      o.q = {s.q[T_FRAC-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

### src/tpc_normalizer.sv
// ----------------------------------------------------------------------------
// tpc_normalizer: plane registers and unit-normal sequencer
// Holds the plane point and normal; after reset or any write it squares,
// takes the integer root and divides each component, one bit a cycle.
// ----------------------------------------------------------------------------
module tpc_normalizer import tpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  output vec_t                 point,
  output nhat_t                nhat [3],
  output logic                 busy
);

  localparam logic [1:0] ST_SQ   = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_IDLE = 2'd3;

  localparam logic [63:0] ROOT_BIT0 = 64'h4000_0000_0000_0000;

  logic [1:0]         state;
  logic [4:0]         cnt;
  vec_t               normal;
  logic [63:0]        acc;
  logic [63:0]        rem;
  logic [63:0]        root;
  logic [63:0]        sbit;
  logic [63:0]        sq;
  logic [63:0]        trial;
  logic [COORD_W-1:0] len;
  logic [COORD_W:0]   dr  [3];
  logic [COORD_W:0]   dsh [3];
  logic [QN_W-1:0]    dq  [3];

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign sq        = 64'($signed(normal[cnt[1:0]]) * $signed(normal[cnt[1:0]]));
  assign trial     = root + sbit;
  assign len       = root[COORD_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsh[i]  = (cnt == 5'd0) ? dr[i] : {dr[i][COORD_W-1:0], 1'b0};
      if (len == '0) begin
        nhat[i] = '0;
      end else if (normal[i][COORD_W-1]) begin
        nhat[i] = -NHAT_W'(dq[i]);
      end else begin
        nhat[i] = NHAT_W'(dq[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SQ;
      cnt       <= '0;
      acc       <= '0;
      point     <= '0;
      normal    <= {32'sd65536, 32'sd0, 32'sd0};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POINT_X:  point[0]  <= cfg_data;
        REG_POINT_Y:  point[1]  <= cfg_data;
        REG_POINT_Z:  point[2]  <= cfg_data;
        REG_NORMAL_X: normal[0] <= cfg_data;
        REG_NORMAL_Y: normal[1] <= cfg_data;
        REG_NORMAL_Z: normal[2] <= cfg_data;
        default: ;
      endcase
      state <= ST_SQ;
      cnt   <= '0;
      acc   <= '0;
    end else begin
      case (state)
        ST_SQ: begin
          acc <= acc + sq;
          if (cnt == 5'd2) begin
            state <= ST_ROOT;
            cnt   <= '0;
            rem   <= acc + sq;
            root  <= '0;
            sbit  <= ROOT_BIT0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_ROOT: begin
          if (rem >= trial) begin
            rem  <= rem - trial;
            root <= (root >> 1) + sbit;
          end else begin
            root <= root >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit == 64'd1) begin
            state <= ST_DIV;
            cnt   <= '0;
            for (int i = 0; i < 3; i++) begin
              dr[i] <= normal[i][COORD_W-1] ? {1'b0, COORD_W'(-normal[i])}
                                            : {1'b0, normal[i]};
              dq[i] <= '0;
            end
          end
        end
        ST_DIV: begin
          for (int i = 0; i < 3; i++) begin
            if (dsh[i] >= {1'b0, len}) begin
              dr[i] <= dsh[i] - {1'b0, len};
              dq[i] <= {dq[i][QN_W-2:0], 1'b1};
            end else begin
              dr[i] <= dsh[i];
              dq[i] <= {dq[i][QN_W-2:0], 1'b0};
            end
          end
          if (cnt == 5'(QN_W - 1)) begin
            state <= ST_IDLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### src/tpc_distance.sv
// ----------------------------------------------------------------------------
// tpc_distance: signed plane distance and vertex classification
// Four stages: v - p, per-axis products, sums, then inside/outside sort
// and setup of both edge divisions.
// ----------------------------------------------------------------------------
module tpc_distance import tpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  vec_t               vin [3],
  input  logic [COORD_W-1:0] color_in,
  input  vec_t               point,
  input  nhat_t              nhat [3],
  output logic               out_valid,
  output clip_t              out_clip,
  output div_t               out_div
);

  logic                     s1_valid, s2_valid, s3_valid;
  vec_t                     s1_v [3];
  vec_t                     s2_v [3];
  vec_t                     s3_v [3];
  logic [COORD_W-1:0]       s1_color, s2_color, s3_color;
  dvec_t                    diff [3];
  dvec_t                    s1_diff [3];
  logic signed [PROD_W-1:0] s2_prod [3][3];
  dist_t                    s3_d [3];

  logic [2:0] ins;
  logic [1:0] count, i0, i1, o0, o1, ab, bb;
  clip_t      clip;
  div_t       dv;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int c = 0; c < 3; c++) begin
        diff[j][c] = DIFF_W'($signed(vin[j][c])) - DIFF_W'($signed(point[c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_v     <= vin;
      s1_diff  <= diff;
      s1_color <= color_in;
      s2_v     <= s1_v;
      s2_color <= s1_color;
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < 3; c++) begin
          s2_prod[j][c] <= PROD_W'($signed(nhat[c])) * PROD_W'($signed(s1_diff[j][c]));
        end
        s3_d[j] <= DIST_W'(s2_prod[j][0]) + DIST_W'(s2_prod[j][1]) + DIST_W'(s2_prod[j][2]);
      end
      s3_v     <= s2_v;
      s3_color <= s2_color;
      out_clip <= clip;
      out_div  <= dv;
    end
  end

  // sort vertices into inside/outside, keeping index order
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ins[j] = ~s3_d[j][DIST_W-1];
    end
    i0 = 2'd0; i1 = 2'd1; o0 = 2'd1; o1 = 2'd2;
    case (ins)
      3'b111: count = CNT_ALL;
      3'b001: begin count = CNT_ONE; i0 = 2'd0; o0 = 2'd1; o1 = 2'd2; end
      3'b010: begin count = CNT_ONE; i0 = 2'd1; o0 = 2'd0; o1 = 2'd2; end
      3'b100: begin count = CNT_ONE; i0 = 2'd2; o0 = 2'd0; o1 = 2'd1; end
      3'b011: begin count = CNT_TWO; i0 = 2'd0; i1 = 2'd1; o0 = 2'd2; end
      3'b101: begin count = CNT_TWO; i0 = 2'd0; i1 = 2'd2; o0 = 2'd1; end
      3'b110: begin count = CNT_TWO; i0 = 2'd1; i1 = 2'd2; o0 = 2'd0; end
      default: count = CNT_NONE;
    endcase
    // second edge: I0-O1 with one inside, I1-O0 with two inside
    ab = (count == CNT_ONE) ? i0 : i1;
    bb = (count == CNT_ONE) ? o1 : o0;

    clip.count = count;
    clip.color = s3_color;
    clip.w[0]  = s3_v[i0];
    clip.w[1]  = s3_v[i1];
    clip.w[2]  = s3_v[2];
    for (int c = 0; c < 3; c++) begin
      clip.da[c] = DIFF_W'($signed(s3_v[o0][c])) - DIFF_W'($signed(s3_v[i0][c]));
      clip.db[c] = DIFF_W'($signed(s3_v[bb][c])) - DIFF_W'($signed(s3_v[ab][c]));
    end
    dv.a.r  = DIV_W'(s3_d[i0]);
    dv.a.q  = '0;
    dv.b.r  = DIV_W'(s3_d[ab]);
    dv.b.q  = '0;
    dv.dena = DIV_W'(s3_d[i0]) - DIV_W'(s3_d[o0]);
    dv.denb = DIV_W'(s3_d[ab]) - DIV_W'(s3_d[bb]);
  end

endmodule

### src/tpc_div_stage.sv
// ----------------------------------------------------------------------------
// tpc_div_stage: one stage of the pipelined edge-parameter divider
// Two restoring steps for each edge, payload carried along.
// ----------------------------------------------------------------------------
module tpc_div_stage import tpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  clip_t in_clip,
  input  div_t  in_div,
  output logic  out_valid,
  output clip_t out_clip,
  output div_t  out_div
);

  div_t nxt;

  always_comb begin
    nxt   = in_div;
    nxt.a = div_step(div_step(in_div.a, in_div.dena), in_div.dena);
    nxt.b = div_step(div_step(in_div.b, in_div.denb), in_div.denb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_clip <= in_clip;
      out_div  <= nxt;
    end
  end

endmodule

### src/tpc_output.sv
// ----------------------------------------------------------------------------
// tpc_output: crossing-point interpolation and result sequencing
// Scales the edge vectors by t, adds to the start vertex and emits zero, one
// or two triangles; holds the pipeline for the second of a pair.
// ----------------------------------------------------------------------------
module tpc_output import tpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  clip_t              in_clip,
  input  div_t               in_div,
  output logic               hold,
  output logic               out_strobe,
  output vec_t               res [3],
  output logic [COORD_W-1:0] out_color,
  output logic               last_of_run
);

  logic        m_valid;
  clip_t       m_clip;
  vec_t        m_offa, m_offb;
  logic        pend;
  logic [63:0] pa [3];
  logic [63:0] pb [3];
  vec_t        xa, xb, base_b;
  vec_t        r0 [3];
  vec_t        r1 [3];

  assign hold = !pend && m_valid && (m_clip.count == CNT_TWO);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pa[c] = 64'($signed(in_clip.da[c])) * 64'($signed({1'b0, in_div.a.q}));
      pb[c] = 64'($signed(in_clip.db[c])) * 64'($signed({1'b0, in_div.b.q}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (!hold) begin
      m_valid <= in_valid;
    end
  end

  // floor(prod / 2^30), only the low coordinate bits are needed
  always_ff @(posedge clk) begin
    if (!hold) begin
      m_clip <= in_clip;
      for (int c = 0; c < 3; c++) begin
        m_offa[c] <= pa[c][T_FRAC+COORD_W-1:T_FRAC];
        m_offb[c] <= pb[c][T_FRAC+COORD_W-1:T_FRAC];
      end
    end
  end

  always_comb begin
    base_b = (m_clip.count == CNT_ONE) ? m_clip.w[0] : m_clip.w[1];
    for (int c = 0; c < 3; c++) begin
      xa[c] = m_clip.w[0][c] + m_offa[c];
      xb[c] = base_b[c] + m_offb[c];
    end
    r0[0] = m_clip.w[0];
    case (m_clip.count)
      CNT_ONE: begin r0[1] = xa;          r0[2] = xb;          end
      CNT_TWO: begin r0[1] = m_clip.w[1]; r0[2] = xa;          end
      default: begin r0[1] = m_clip.w[1]; r0[2] = m_clip.w[2]; end
    endcase
    r1[0] = m_clip.w[1];
    r1[1] = xa;
    r1[2] = xb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_strobe <= 1'b0;
      pend       <= 1'b0;
    end else if (pend) begin
      out_strobe  <= 1'b1;
      res         <= r1;
      out_color   <= m_clip.color;
      last_of_run <= 1'b1;
      pend        <= 1'b0;
    end else if (m_valid && m_clip.count != CNT_NONE) begin
      out_strobe  <= 1'b1;
      res         <= r0;
      out_color   <= m_clip.color;
      last_of_run <= (m_clip.count != CNT_TWO);
      pend        <= (m_clip.count == CNT_TWO);
    end else begin
      out_strobe <= 1'b0;
    end
  end

  a_hold_starts_pair: assert property (@(posedge clk) disable iff (rst)
    hold |=> pend && out_strobe && !last_of_run)
    else $error("pair not started after hold");

  a_pend_shows_first: assert property (@(posedge clk) disable iff (rst)
    pend |-> out_strobe && !last_of_run)
    else $error("pending second result without first");

  a_pair_completes: assert property (@(posedge clk) disable iff (rst)
    out_strobe && !last_of_run |=> out_strobe && last_of_run)
    else $error("second triangle of pair missing");

endmodule

### src/triangle_plane_clipper_top.sv
// ----------------------------------------------------------------------------
// triangle_plane_clipper_top: clip one triangle against a configured plane
// Pipelined distance, divide and interpolate; emits zero, one or two
// triangles per input with the color carried through.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: drive vert*/tri_color with start high; the transfer happens on a
//    rising edge with start high and busy low.
//  - Config: cfg_valid/cfg_ready write channel, cfg_index selects point x/y/z
//    (0..2) or normal x/y/z (3..5); other indexes write no register but still
//    restart the normal scaling. Write only while no triangle is in flight.
//  - After reset and after every config write busy stays high while the
//    normal is scaled to unit length (3 square steps, 32 root steps,
//    25 divide steps, one bit a cycle).
//  - Results: out_strobe marks each result for one cycle; last_of_run flags
//    the final triangle of an input. Inputs with no inside vertex give none.
//  - Path: an input passes the distance stages, the divider stages, the
//    interpolation register and the result register before its first strobe.
//  - Throughput: one triangle a cycle while the normal is not being scaled and
//    each gives at most one result; an input that splits in two holds the
//    inputs for its second triangle, since the result port carries one
//    triangle a cycle. busy rises for one cycle; all but the result stage hold.
//  - The receiver cannot stall: results are always taken as presented.
// ----------------------------------------------------------------------------
module triangle_plane_clipper_top import tpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [COORD_W-1:0]   vert0_x,
  input  logic [COORD_W-1:0]   vert0_y,
  input  logic [COORD_W-1:0]   vert0_z,
  input  logic [COORD_W-1:0]   vert1_x,
  input  logic [COORD_W-1:0]   vert1_y,
  input  logic [COORD_W-1:0]   vert1_z,
  input  logic [COORD_W-1:0]   vert2_x,
  input  logic [COORD_W-1:0]   vert2_y,
  input  logic [COORD_W-1:0]   vert2_z,
  input  logic [COORD_W-1:0]   tri_color,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  output logic                 out_strobe,
  output logic [COORD_W-1:0]   out0_x,
  output logic [COORD_W-1:0]   out0_y,
  output logic [COORD_W-1:0]   out0_z,
  output logic [COORD_W-1:0]   out1_x,
  output logic [COORD_W-1:0]   out1_y,
  output logic [COORD_W-1:0]   out1_z,
  output logic [COORD_W-1:0]   out2_x,
  output logic [COORD_W-1:0]   out2_y,
  output logic [COORD_W-1:0]   out2_z,
  output logic [COORD_W-1:0]   out_color,
  output logic                 last_of_run
);

  vec_t  vin [3];
  vec_t  point;
  nhat_t nhat [3];
  vec_t  res [3];
  logic  norm_busy;
  logic  hold;
  logic  adv;
  logic  accept;

  // divider chain: index 0 is the classify stage output
  logic  dvalid [DIV_STAGES+1];
  clip_t dclip  [DIV_STAGES+1];
  div_t  ddiv   [DIV_STAGES+1];

  assign vin[0] = {vert0_z, vert0_y, vert0_x};
  assign vin[1] = {vert1_z, vert1_y, vert1_x};
  assign vin[2] = {vert2_z, vert2_y, vert2_x};

  // second triangle of a pair freezes all but the result stage for one cycle
  assign adv    = !hold;
  assign busy   = norm_busy || hold;
  assign accept = start && !busy;

  tpc_normalizer u_norm (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point     (point),
    .nhat      (nhat),
    .busy      (norm_busy)
  );

  tpc_distance u_dist (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (accept),
    .vin       (vin),
    .color_in  (tri_color),
    .point     (point),
    .nhat      (nhat),
    .out_valid (dvalid[0]),
    .out_clip  (dclip[0]),
    .out_div   (ddiv[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tpc_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (dvalid[g]),
      .in_clip   (dclip[g]),
      .in_div    (ddiv[g]),
      .out_valid (dvalid[g+1]),
      .out_clip  (dclip[g+1]),
      .out_div   (ddiv[g+1])
    );
  end

  tpc_output u_out (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (dvalid[DIV_STAGES]),
    .in_clip     (dclip[DIV_STAGES]),
    .in_div      (ddiv[DIV_STAGES]),
    .hold        (hold),
    .out_strobe  (out_strobe),
    .res         (res),
    .out_color   (out_color),
    .last_of_run (last_of_run)
  );

  assign out0_x = res[0][0];
  assign out0_y = res[0][1];
  assign out0_z = res[0][2];
  assign out1_x = res[1][0];
  assign out1_y = res[1][1];
  assign out1_z = res[1][2];
  assign out2_x = res[2][0];
  assign out2_y = res[2][1];
  assign out2_z = res[2][2];

endmodule
